### hdl/sfswa_pkg.sv
// shared constants for the storm forward speed wind adder
`default_nettype none
package sfswa_pkg;

   localparam logic [30:0] QONE               = 31'h4000_0000;
   localparam logic [14:0] FULL_TURN          = 15'd23040;
   localparam logic [14:0] QUARTER_TURN       = 15'd5760;
   localparam logic [14:0] HALF_TURN          = 15'd11520;
   localparam logic [14:0] THREE_QUARTER_TURN = 15'd17280;
   localparam logic [34:0] RAD_PER_UNIT_Q46   = 35'd19190098060;
   localparam logic [32:0] ROUND_HALF         = 33'd8192;
   localparam logic [16:0] OUT_MAX            = 17'h1FFFF;

   // taylor series divisors and their 2^32 reciprocals
   localparam int NUM_ITER = 5;
   localparam logic [6:0]  DIV_K     [NUM_ITER] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
   localparam logic [29:0] DIV_RECIP [NUM_ITER] = '{30'd39045157, 30'd59652323,
                                                    30'd102261126, 30'd214748364,
                                                    30'd715827882};

   localparam int SINE_LAT    = 3 * NUM_ITER + 5;
   localparam int RATIO_STEPS = 30;
   localparam int SQRT_STEPS  = 32;
   localparam int ALIGN_DLY   = RATIO_STEPS + 1;
   localparam int SINE_DLY    = RATIO_STEPS - SINE_LAT;
   localparam int PIPE_DEPTH  = RATIO_STEPS + SQRT_STEPS + 8;

endpackage
`default_nettype wire

### hdl/sfswa_sine.sv
// pipelined fixed point sine over a full turn
`default_nettype none
module sfswa_sine (
   input  logic               clock,
   input  logic [14:0]        ang,
   output logic signed [31:0] sine
);

   localparam int N = sfswa_pkg::NUM_ITER;

   logic [1:0]  quad;
   logic [12:0] rem_ang;
   logic [12:0] arg_in;

   logic [12:0] s1_arg_ff;
   logic        s1_neg_ff;
   logic [47:0] x_prod;
   logic [30:0] s2_x_ff;
   logic        s2_neg_ff;
   logic [61:0] x2_prod;
   logic [31:0] s3_x2_ff;
   logic [30:0] s3_x_ff;
   logic        s3_neg_ff;

   logic [31:0] a_p_ff   [N];
   logic [31:0] a_x2_ff  [N];
   logic [30:0] a_x_ff   [N];
   logic        a_neg_ff [N];
   logic [29:0] b_q0_ff  [N];
   logic [31:0] b_p_ff   [N];
   logic [31:0] b_x2_ff  [N];
   logic [30:0] b_x_ff   [N];
   logic        b_neg_ff [N];
   logic [30:0] c_t_ff   [N];
   logic [31:0] c_x2_ff  [N-1];
   logic [30:0] c_x_ff   [N];
   logic        c_neg_ff [N];

   logic [61:0]        s_prod;
   logic [30:0]        f1_s_ff;
   logic               f1_neg_ff;
   logic [30:0]        capped;
   logic signed [31:0] s_pos;
   logic signed [31:0] sine_ff;

   always_comb begin
      if (ang >= sfswa_pkg::THREE_QUARTER_TURN) begin
         quad    = 2'd3;
         rem_ang = 13'(ang - sfswa_pkg::THREE_QUARTER_TURN);
      end else if (ang >= sfswa_pkg::HALF_TURN) begin
         quad    = 2'd2;
         rem_ang = 13'(ang - sfswa_pkg::HALF_TURN);
      end else if (ang >= sfswa_pkg::QUARTER_TURN) begin
         quad    = 2'd1;
         rem_ang = 13'(ang - sfswa_pkg::QUARTER_TURN);
      end else begin
         quad    = 2'd0;
         rem_ang = ang[12:0];
      end
      arg_in = quad[0] ? 13'(sfswa_pkg::QUARTER_TURN - 15'(rem_ang)) : rem_ang;
   end

   assign x_prod  = 48'(s1_arg_ff) * 48'(sfswa_pkg::RAD_PER_UNIT_Q46);
   assign x2_prod = 62'(s2_x_ff) * 62'(s2_x_ff);

   always_ff @(posedge clock) begin
      s1_arg_ff <= arg_in;
      s1_neg_ff <= quad[1];
      s2_x_ff   <= x_prod[46:16];
      s2_neg_ff <= s1_neg_ff;
      s3_x2_ff  <= x2_prod[61:30];
      s3_x_ff   <= s2_x_ff;
      s3_neg_ff <= s2_neg_ff;
   end

   for (genvar i = 0; i < N; i++) begin : g_iter
      logic [30:0] t_src;
      logic [31:0] x2_src;
      logic [30:0] x_src;
      logic        neg_src;
      logic [62:0] p_prod;
      logic [61:0] q_prod;
      logic [31:0] q_back;
      logic [31:0] r_left;
      logic [29:0] q_fix;

      if (i == 0) begin : g_first
         assign t_src   = sfswa_pkg::QONE;
         assign x2_src  = s3_x2_ff;
         assign x_src   = s3_x_ff;
         assign neg_src = s3_neg_ff;
      end else begin : g_next
         assign t_src   = c_t_ff[i-1];
         assign x2_src  = c_x2_ff[i-1];
         assign x_src   = c_x_ff[i-1];
         assign neg_src = c_neg_ff[i-1];
      end

      assign p_prod = 63'(x2_src) * 63'(t_src);
      assign q_prod = 62'(a_p_ff[i]) * 62'(sfswa_pkg::DIV_RECIP[i]);
      assign q_back = 32'(b_q0_ff[i]) * 32'(sfswa_pkg::DIV_K[i]);
      assign r_left = b_p_ff[i] - q_back;
      assign q_fix  = b_q0_ff[i] + 30'(r_left >= 32'(sfswa_pkg::DIV_K[i]));

      always_ff @(posedge clock) begin
         a_p_ff[i]   <= p_prod[61:30];
         a_x2_ff[i]  <= x2_src;
         a_x_ff[i]   <= x_src;
         a_neg_ff[i] <= neg_src;
         b_q0_ff[i]  <= q_prod[61:32];
         b_p_ff[i]   <= a_p_ff[i];
         b_x2_ff[i]  <= a_x2_ff[i];
         b_x_ff[i]   <= a_x_ff[i];
         b_neg_ff[i] <= a_neg_ff[i];
         c_t_ff[i]   <= sfswa_pkg::QONE - 31'(q_fix);
         c_x_ff[i]   <= b_x_ff[i];
         c_neg_ff[i] <= b_neg_ff[i];
      end

      if (i < N - 1) begin : g_keep_x2
         always_ff @(posedge clock) begin
            c_x2_ff[i] <= b_x2_ff[i];
         end
      end
   end

   assign s_prod = 62'(c_x_ff[N-1]) * 62'(c_t_ff[N-1]);
   assign capped = (f1_s_ff > sfswa_pkg::QONE) ? sfswa_pkg::QONE : f1_s_ff;
   assign s_pos  = $signed({1'b0, capped});

   always_ff @(posedge clock) begin
      f1_s_ff   <= s_prod[60:30];
      f1_neg_ff <= c_neg_ff[N-1];
      sine_ff   <= f1_neg_ff ? -s_pos : s_pos;
   end

   assign sine = sine_ff;

endmodule
`default_nettype wire

### hdl/sfswa_isqrt.sv
// pipelined integer square root, one result bit per stage
`default_nettype none
module sfswa_isqrt (
   input  logic        clock,
   input  logic [62:0] radicand,
   output logic [31:0] root
);

   localparam int S = sfswa_pkg::SQRT_STEPS;

   logic [32:0] rem_ff  [S-1];
   logic [63:0] bits_ff [S-1];
   logic [31:0] root_ff [S];

   for (genvar i = 0; i < S; i++) begin : g_step
      logic [32:0] rem_src;
      logic [63:0] bits_src;
      logic [31:0] root_src;
      logic [34:0] cur;
      logic [34:0] trial;
      logic        take;

      if (i == 0) begin : g_first
         assign rem_src  = '0;
         assign bits_src = {1'b0, radicand};
         assign root_src = '0;
      end else begin : g_next
         assign rem_src  = rem_ff[i-1];
         assign bits_src = bits_ff[i-1];
         assign root_src = root_ff[i-1];
      end

      assign cur   = {rem_src, bits_src[63:62]};
      assign trial = {1'b0, root_src, 2'b01};
      assign take  = (cur >= trial);

      always_ff @(posedge clock) begin
         root_ff[i] <= {root_src[30:0], take};
      end

      if (i < S - 1) begin : g_more
         logic [34:0] diff;
         assign diff = cur - trial;
         always_ff @(posedge clock) begin
            rem_ff[i]  <= take ? diff[32:0] : cur[32:0];
            bits_ff[i] <= {bits_src[61:0], 2'b00};
         end
      end
   end

   assign root = root_ff[S-1];

endmodule
`default_nettype wire

### hdl/storm_forward_speed_wind_adder.sv
// top level: storm forward speed wind adder pipeline
`default_nettype none
// Takes one grid point per clock cycle: busy stays low, so a start on any cycle is a
// transfer. The result of each point appears on rsp_total_wind_speed with rsp_strobe high
// for one cycle, in the order the points went in. The pipeline depth is set by the
// 30-stage long divider for the radius factor plus the 32-stage square root of the
// magnitude; the receiver cannot stall and nothing is buffered.
module storm_forward_speed_wind_adder (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_sym_wind_speed,
   input  logic [14:0] req_wind_direction,
   input  logic [15:0] req_storm_motion_u,
   input  logic [15:0] req_storm_motion_v,
   input  logic [15:0] req_center_distance,
   input  logic [15:0] req_max_wind_radius,
   output logic        rsp_strobe,
   output logic [16:0] rsp_total_wind_speed
);

   localparam int DEPTH = sfswa_pkg::PIPE_DEPTH;
   localparam int STEPS = sfswa_pkg::RATIO_STEPS;
   localparam int ALIGN = sfswa_pkg::ALIGN_DLY;
   localparam int SDLY  = sfswa_pkg::SINE_DLY;

   typedef struct packed {
      logic [15:0] w;
      logic [15:0] mu;
      logic [15:0] mv;
   } carry_type;

   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] vld_in;

   logic [15:0] in_w_ff;
   logic [14:0] in_dir_ff;
   logic [15:0] in_mu_ff;
   logic [15:0] in_mv_ff;
   logic [15:0] in_d_ff;
   logic [15:0] in_r_ff;

   logic [14:0] dir_mod;
   logic [14:0] cos_sum;
   logic [14:0] cos_ang;
   logic [14:0] ang_sin_ff;
   logic [14:0] ang_cos_ff;

   logic [32:0] dv_rem_ff  [STEPS];
   logic [32:0] dv_den_ff  [STEPS];
   logic [29:0] dv_q_ff    [STEPS+1];
   logic        dv_zero_ff [STEPS+1];

   logic signed [31:0] sin_val;
   logic signed [31:0] cos_val;
   logic signed [31:0] sin_dly_ff [SDLY];
   logic signed [31:0] cos_dly_ff [SDLY];
   carry_type          carry_ff   [ALIGN];

   carry_type          cv;
   logic [29:0]        f_val;
   logic signed [16:0] w_s;
   logic signed [30:0] f_s;
   logic signed [47:0] wc_ff;
   logic signed [47:0] ws_ff;
   logic signed [47:0] fu_ff;
   logic signed [47:0] fv_ff;
   logic signed [47:0] uu_ff;
   logic signed [47:0] vv_ff;
   logic [47:0]        uu_mag;
   logic [47:0]        vv_mag;
   logic [30:0]        a_ff;
   logic [30:0]        b_ff;
   logic [61:0]        asq_ff;
   logic [61:0]        bsq_ff;
   logic [62:0]        sum_ff;
   logic [31:0]        root;
   logic [32:0]        rounded;
   logic [18:0]        scaled;
   logic [16:0]        res_ff;

   assign busy   = 1'b0;
   assign vld_in = {vld_ff[DEPTH-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_w_ff   <= req_sym_wind_speed;
      in_dir_ff <= req_wind_direction;
      in_mu_ff  <= req_storm_motion_u;
      in_mv_ff  <= req_storm_motion_v;
      in_d_ff   <= req_center_distance;
      in_r_ff   <= req_max_wind_radius;
   end

   // direction folding into one turn
   always_comb begin
      dir_mod = (in_dir_ff >= sfswa_pkg::FULL_TURN) ? in_dir_ff - sfswa_pkg::FULL_TURN
                                                    : in_dir_ff;
      cos_sum = dir_mod + sfswa_pkg::QUARTER_TURN;
      cos_ang = (cos_sum >= sfswa_pkg::FULL_TURN) ? cos_sum - sfswa_pkg::FULL_TURN
                                                  : cos_sum;
   end

   always_ff @(posedge clock) begin
      ang_sin_ff    <= dir_mod;
      ang_cos_ff    <= cos_ang;
      dv_rem_ff[0]  <= 33'(32'(in_r_ff) * 32'(in_d_ff));
      dv_den_ff[0]  <= 33'(in_r_ff) * 33'(in_r_ff) + 33'(in_d_ff) * 33'(in_d_ff);
      dv_q_ff[0]    <= '0;
      dv_zero_ff[0] <= (in_r_ff == 16'd0) && (in_d_ff == 16'd0);
   end

   // radius factor long division, one quotient bit per stage
   for (genvar i = 1; i <= STEPS; i++) begin : g_div
      logic [33:0] dbl;
      logic [33:0] diff;
      logic        take;

      assign dbl  = {dv_rem_ff[i-1], 1'b0};
      assign diff = dbl - {1'b0, dv_den_ff[i-1]};
      assign take = (dbl >= {1'b0, dv_den_ff[i-1]});

      always_ff @(posedge clock) begin
         dv_q_ff[i]    <= {dv_q_ff[i-1][28:0], take};
         dv_zero_ff[i] <= dv_zero_ff[i-1];
      end

      if (i < STEPS) begin : g_more
         always_ff @(posedge clock) begin
            dv_rem_ff[i] <= take ? diff[32:0] : dbl[32:0];
            dv_den_ff[i] <= dv_den_ff[i-1];
         end
      end
   end

   sfswa_sine u_sin (
      .clock (clock),
      .ang   (ang_sin_ff),
      .sine  (sin_val)
   );

   sfswa_sine u_cos (
      .clock (clock),
      .ang   (ang_cos_ff),
      .sine  (cos_val)
   );

   always_ff @(posedge clock) begin
      sin_dly_ff[0] <= sin_val;
      cos_dly_ff[0] <= cos_val;
      for (int k = 1; k < SDLY; k++) begin
         sin_dly_ff[k] <= sin_dly_ff[k-1];
         cos_dly_ff[k] <= cos_dly_ff[k-1];
      end
      carry_ff[0] <= '{w: in_w_ff, mu: in_mu_ff, mv: in_mv_ff};
      for (int k = 1; k < ALIGN; k++) begin
         carry_ff[k] <= carry_ff[k-1];
      end
   end

   assign cv    = carry_ff[ALIGN-1];
   assign f_val = dv_zero_ff[STEPS] ? 30'd0 : dv_q_ff[STEPS];
   assign w_s   = $signed({1'b0, cv.w});
   assign f_s   = $signed({1'b0, f_val});

   assign uu_mag = uu_ff[47] ? 48'(-uu_ff) : 48'(uu_ff);
   assign vv_mag = vv_ff[47] ? 48'(-vv_ff) : 48'(vv_ff);

   always_ff @(posedge clock) begin
      wc_ff  <= w_s * cos_dly_ff[SDLY-1];
      ws_ff  <= w_s * sin_dly_ff[SDLY-1];
      fu_ff  <= f_s * $signed(cv.mu);
      fv_ff  <= f_s * $signed(cv.mv);
      uu_ff  <= wc_ff + fu_ff;
      vv_ff  <= ws_ff + fv_ff;
      a_ff   <= uu_mag[46:16];
      b_ff   <= vv_mag[46:16];
      asq_ff <= 62'(a_ff) * 62'(a_ff);
      bsq_ff <= 62'(b_ff) * 62'(b_ff);
      sum_ff <= 63'(asq_ff) + 63'(bsq_ff);
   end

   sfswa_isqrt u_root (
      .clock    (clock),
      .radicand (sum_ff),
      .root     (root)
   );

   assign rounded = 33'(root) + sfswa_pkg::ROUND_HALF;
   assign scaled  = rounded[32:14];

   always_ff @(posedge clock) begin
      res_ff <= (scaled > 19'(sfswa_pkg::OUT_MAX)) ? sfswa_pkg::OUT_MAX : scaled[16:0];
   end

   assign rsp_strobe           = vld_ff[DEPTH-1];
   assign rsp_total_wind_speed = res_ff;

endmodule
`default_nettype wire

### test/tb_storm_forward_speed_wind_adder.sv
// testbench for the storm forward speed wind adder: directed and random grid points
module tb_storm_forward_speed_wind_adder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY     = 70;
   localparam int RAND_POINTS = 1500;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      logic [15:0] wind;
      logic [14:0] dir;
      logic [15:0] mu;
      logic [15:0] mv;
      logic [15:0] center;
      logic [15:0] rmax;
   } grid_point_type;

   // expected wind magnitudes in transfer order
   class wind_scoreboard;
      logic [16:0] pending[$];
      int errors;
      int checked;

      function logic [63:0] quadrant_sine(logic [63:0] r);
         logic [63:0] x;
         logic [63:0] x2;
         logic [63:0] t;
         logic [63:0] s;
         x  = (r * 64'd19190098060) >> 16;
         x2 = (x * x) >> 30;
         t  = (64'd1 << 30) - x2 / 110;
         t  = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
         t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
         t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
         t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
         s  = (x * t) >> 30;
         return (s > (64'd1 << 30)) ? (64'd1 << 30) : s;
      endfunction

      function longint signed_sine(int unsigned a);
         int unsigned quad;
         int unsigned rem;
         longint s;
         quad = (a % 23040) / 5760;
         rem  = (a % 23040) % 5760;
         s = longint'(quadrant_sine((quad & 1) ? 5760 - rem : rem));
         return (quad >= 2) ? -s : s;
      endfunction

      function logic [63:0] int_sqrt(logic [63:0] n);
         logic [63:0] res;
         logic [63:0] b;
         res = 0;
         b = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= res + b) begin
               n = n - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      function logic [16:0] wind_magnitude(grid_point_type p);
         int unsigned dir;
         longint w;
         longint f;
         longint uu;
         longint vv;
         logic [63:0] den;
         logic [63:0] a;
         logic [63:0] b;
         logic [63:0] m;
         logic [63:0] res;
         logic [127:0] num;
         w   = longint'(p.wind);
         dir = int'(p.dir) % 23040;
         den = 64'(p.rmax) * p.rmax + 64'(p.center) * p.center;
         f = 0;
         if (den != 0) begin
            num = (128'(p.rmax) * p.center) << 30;
            f = longint'(num / den);
         end
         uu = w * signed_sine((dir + 5760) % 23040) + f * longint'($signed(p.mu));
         vv = w * signed_sine(dir) + f * longint'($signed(p.mv));
         a = ((uu < 0) ? -uu : uu) >> 16;
         b = ((vv < 0) ? -vv : vv) >> 16;
         m = int_sqrt(a * a + b * b);
         res = (m + 8192) >> 14;
         if (res > 131071) res = 131071;
         return res[16:0];
      endfunction

      function void note_transfer(grid_point_type p);
         pending.push_back(wind_magnitude(p));
      endfunction

      function void check_result(logic [16:0] actual);
         logic [16:0] exp_val;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %0d", $time, actual);
            errors++;
         end else begin
            exp_val = pending.pop_front();
            if (actual !== exp_val) begin
               $display("%0t: total_wind_speed expected %0d actual %0d",
                        $time, exp_val, actual);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [15:0] req_sym_wind_speed  = '0;
   logic [14:0] req_wind_direction  = '0;
   logic [15:0] req_storm_motion_u  = '0;
   logic [15:0] req_storm_motion_v  = '0;
   logic [15:0] req_center_distance = '0;
   logic [15:0] req_max_wind_radius = '0;
   logic        rsp_strobe;
   logic [16:0] rsp_total_wind_speed;
   longint      cycles = 0;
   wind_scoreboard board = new();
   grid_point_type drive_pt;

   storm_forward_speed_wind_adder i_dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_strobe) board.check_result(rsp_total_wind_speed);
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic idle_gap();
      int n;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) n = 0;
      else if (pick < 92) n = $urandom_range(1, 3);
      else n = $urandom_range(4, 30);
      repeat (n) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // start stays high across back-to-back transfers
   task automatic send_point(grid_point_type p, bit gaps);
      if (gaps) idle_gap();
      start               <= 1'b1;
      req_sym_wind_speed  <= p.wind;
      req_wind_direction  <= p.dir;
      req_storm_motion_u  <= p.mu;
      req_storm_motion_v  <= p.mv;
      req_center_distance <= p.center;
      req_max_wind_radius <= p.rmax;
      do @(posedge clock); while (busy);
      board.note_transfer(p);
   endtask

   function automatic grid_point_type random_point();
      grid_point_type p;
      int pick;
      p.wind   = 16'($urandom);
      p.dir    = 15'((($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 23039)));
      p.mu     = 16'($urandom);
      p.mv     = 16'($urandom);
      p.center = 16'($urandom);
      p.rmax   = 16'($urandom);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         p.center = 16'd0;
         p.rmax   = 16'd0;
      end else if (pick < 4) begin
         p.center = 16'($urandom_range(0, 2000));
         p.rmax   = 16'($urandom_range(0, 2000));
      end else if (pick == 4) begin
         p.center = p.rmax;
      end
      if ($urandom_range(0, 9) == 0) p.dir = 15'(5760 * $urandom_range(0, 4));
      return p;
   endfunction

   initial begin
      grid_point_type p;
      int unsigned dirs[$];
      dirs = '{0, 5760, 11520, 17280, 23039, 23040, 32767, 1, 2880};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dirs[i]) begin
         p = '{16'hFFFF, dirs[i][14:0], 16'h0, 16'h0, 16'h0, 16'h0};
         send_point(p, 0);
      end
      p = '{16'h0, 15'd0, 16'h7FFF, 16'h8000, 16'd100, 16'd100};
      send_point(p, 0);
      p = '{16'hFFFF, 15'd2880, 16'h7FFF, 16'h7FFF, 16'd500, 16'd500};
      send_point(p, 0);
      p = '{16'hFFFF, 15'd14400, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF};
      send_point(p, 1);
      p = '{16'd1234, 15'd0, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0};
      send_point(p, 0);
      p = '{16'd1234, 15'd100, 16'h8000, 16'h7FFF, 16'h0, 16'hFFFF};
      send_point(p, 0);
      p = '{16'h0, 15'd0, 16'h0, 16'h0, 16'h0, 16'h0};
      send_point(p, 1);
      p = '{16'h8000, 15'd17280, 16'hFFFF, 16'h0001, 16'd1, 16'hFFFF};
      send_point(p, 0);

      for (int i = 0; i < RAND_POINTS; i++) begin
         drive_pt = random_point();
         send_point(drive_pt, (i / 200) % 2 == 1);
      end
      start <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("covered %0d grid points: direction quadrants and wraps, zero distances,",
               board.checked);
      $display("saturating magnitudes and random motion vectors with random start gaps");
      if (board.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

### files.f
hdl/sfswa_pkg.sv
hdl/sfswa_sine.sv
hdl/sfswa_isqrt.sv
hdl/storm_forward_speed_wind_adder.sv
test/tb_storm_forward_speed_wind_adder.sv
